[rtl/lqsb_pkg.sv]
// Shared types and constants for the linear queue sort bucket block.
// Holds command codes, status codes, cell control word and grouping helper.
// No dependencies.
package lqsb_pkg;

  localparam int VAL_W  = 7;
  localparam int KIND_W = 3;
  localparam int STAT_W = 2;
  localparam int GRP_W  = 2;

  localparam logic [KIND_W-1:0] KIND_ENQ  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DEQ  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LIST = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SORT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CAT  = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NO_GROUP = 2'd3;

  localparam logic [GRP_W-1:0] GRP_FIRST = 2'd0;
  localparam logic [GRP_W-1:0] GRP_LAST  = 2'd3;

  // Group bounds: below 10, up to 19, up to 29, up to 99.
  localparam logic [VAL_W-1:0] LIM_G0 = 7'd10;
  localparam logic [VAL_W-1:0] LIM_G1 = 7'd19;
  localparam logic [VAL_W-1:0] LIM_G2 = 7'd29;
  localparam logic [VAL_W-1:0] LIM_G3 = 7'd99;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT,
    CELL_ROTATE,
    CELL_SORT
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic              phase;
    logic [VAL_W-1:0]  wr_value;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LIST,
    S_SORT,
    S_CAT,
    S_CAT_END
  } ctrl_state_t;

  // Bit GRP_W is the in-group flag, the low bits the group number.
  function automatic logic [GRP_W:0] group_of(input logic [VAL_W-1:0] v);
    logic [GRP_W:0] g;
    if (v < LIM_G0)       g = {1'b1, 2'd0};
    else if (v <= LIM_G1) g = {1'b1, 2'd1};
    else if (v <= LIM_G2) g = {1'b1, 2'd2};
    else if (v <= LIM_G3) g = {1'b1, 2'd3};
    else                  g = {1'b0, 2'd0};
    return g;
  endfunction

endpackage

[rtl/lqsb_cell.sv]
// One storage cell of the queue chain: holds one entry, loads, shifts,
// rotates or does a compare-exchange with a neighbor. Depends on lqsb_pkg.
module lqsb_cell #(
  parameter int DEPTH = 16,
  parameter int IDX   = 0
) (
  input  logic                          clk,
  input  lqsb_pkg::cell_ctrl_t          ctrl,
  input  logic [$clog2(DEPTH+1)-1:0]    count,
  input  logic [lqsb_pkg::VAL_W-1:0]    head,
  input  logic [lqsb_pkg::VAL_W-1:0]    left,
  input  logic [lqsb_pkg::VAL_W-1:0]    right,
  output logic [lqsb_pkg::VAL_W-1:0]    q
);
  import lqsb_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] POS  = CW'(IDX);
  localparam logic [CW-1:0] POS1 = CW'(IDX + 1);
  localparam logic PAR      = 1'(IDX % 2);
  localparam logic HAS_LEFT = (IDX > 0);

  logic [VAL_W-1:0] q_next;

  always_comb begin
    q_next = q;
    case (ctrl.op)
      CELL_LOAD: begin
        if (POS == count) q_next = ctrl.wr_value;
      end
      CELL_SHIFT: begin
        q_next = right;
      end
      CELL_ROTATE: begin
        // last live cell wraps the head around; dead cells hold
        if (POS1 == count)     q_next = head;
        else if (POS1 < count) q_next = right;
      end
      CELL_SORT: begin
        if (PAR == ctrl.phase && POS1 < count) begin
          if (right < q) q_next = right;
        end else if (HAS_LEFT && PAR != ctrl.phase && POS < count) begin
          if (left > q) q_next = left;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

[rtl/lqsb_ctrl.sv]
// Command sequencer for the queue: head and fill counters, walk state,
// categorize hold-back word and the registered result port. Depends on lqsb_pkg.
module lqsb_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lqsb_pkg::KIND_W-1:0]   kind,
  input  logic [lqsb_pkg::VAL_W-1:0]    value,
  input  logic [lqsb_pkg::VAL_W-1:0]    head_val,
  output logic                          busy,
  output lqsb_pkg::cell_ctrl_t          cell_ctrl,
  output logic [$clog2(DEPTH+1)-1:0]    count,
  output logic                          strobe,
  output logic [lqsb_pkg::STAT_W-1:0]   status,
  output logic [lqsb_pkg::VAL_W-1:0]    data,
  output logic [lqsb_pkg::GRP_W-1:0]    group,
  output logic                          last
);
  import lqsb_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);
  localparam logic [CW-1:0] ONE  = CW'(1);

  ctrl_state_t state, state_next;

  logic [CW-1:0]    fill, fill_next;
  logic [CW-1:0]    head_idx, head_idx_next;
  logic [CW-1:0]    step, step_next;
  logic [CW-1:0]    cnt_m1;
  logic [GRP_W-1:0] grp, grp_next;
  logic             pend_valid, pend_valid_next;
  logic [VAL_W-1:0] pend_data, pend_data_next;
  logic [GRP_W-1:0] pend_grp, pend_grp_next;
  logic [GRP_W:0]   head_grp;
  logic             grp_hit;
  logic             walk_end;

  logic             emit;
  logic [STAT_W-1:0] emit_status;
  logic [VAL_W-1:0] emit_data;
  logic [GRP_W-1:0] emit_group;
  logic             emit_last;

  assign count    = fill - head_idx;
  assign cnt_m1   = count - ONE;
  assign busy     = (state != S_IDLE);
  assign head_grp = group_of(head_val);
  assign grp_hit  = head_grp[GRP_W] && (head_grp[GRP_W-1:0] == grp);
  assign walk_end = (step == cnt_m1);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (kind)
            KIND_LIST: if (count != '0) state_next = S_LIST;
            KIND_SORT: if (count > ONE) state_next = S_SORT;
            KIND_CAT:  if (count != '0) state_next = S_CAT;
            default: ;
          endcase
        end
      end
      S_LIST:    if (walk_end) state_next = S_IDLE;
      S_SORT:    if (walk_end) state_next = S_IDLE;
      S_CAT:     if (walk_end && grp == GRP_LAST) state_next = S_CAT_END;
      S_CAT_END: state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cell_ctrl.op       = CELL_HOLD;
    cell_ctrl.phase    = step[0];
    cell_ctrl.wr_value = value;
    fill_next       = fill;
    head_idx_next   = head_idx;
    step_next       = step;
    grp_next        = grp;
    pend_valid_next = pend_valid;
    pend_data_next  = pend_data;
    pend_grp_next   = pend_grp;
    emit        = 1'b0;
    emit_status = STAT_OK;
    emit_data   = '0;
    emit_group  = GRP_FIRST;
    emit_last   = 1'b1;
    case (state)
      S_IDLE: begin
        step_next       = '0;
        grp_next        = GRP_FIRST;
        pend_valid_next = 1'b0;
        if (start) begin
          case (kind)
            KIND_ENQ: begin
              emit = 1'b1;
              if (fill == FULL) begin
                emit_status = STAT_OVERFLOW;
              end else begin
                cell_ctrl.op = CELL_LOAD;
                fill_next    = fill + ONE;
              end
            end
            KIND_DEQ: begin
              emit = 1'b1;
              if (count == '0) begin
                emit_status = STAT_EMPTY;
              end else begin
                emit_data     = head_val;
                cell_ctrl.op  = CELL_SHIFT;
                head_idx_next = head_idx + ONE;
              end
            end
            KIND_LIST, KIND_CAT: begin
              if (count == '0) begin
                emit        = 1'b1;
                emit_status = STAT_EMPTY;
              end
            end
            KIND_SORT: begin
              if (count <= ONE) emit = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_LIST: begin
        cell_ctrl.op = CELL_ROTATE;
        emit         = 1'b1;
        emit_data    = head_val;
        emit_last    = walk_end;
        step_next    = step + ONE;
      end
      S_SORT: begin
        cell_ctrl.op = CELL_SORT;
        step_next    = step + ONE;
        if (walk_end) emit = 1'b1;
      end
      S_CAT: begin
        cell_ctrl.op = CELL_ROTATE;
        // hold one match back so the final one can carry last
        if (grp_hit) begin
          emit            = pend_valid;
          emit_data       = pend_data;
          emit_group      = pend_grp;
          emit_last       = 1'b0;
          pend_valid_next = 1'b1;
          pend_data_next  = head_val;
          pend_grp_next   = grp;
        end
        if (walk_end) begin
          step_next = '0;
          grp_next  = grp + 2'd1;
        end else begin
          step_next = step + ONE;
        end
      end
      S_CAT_END: begin
        emit = 1'b1;
        if (pend_valid) begin
          emit_data  = pend_data;
          emit_group = pend_grp;
        end else begin
          emit_status = STAT_NO_GROUP;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      head_idx   <= '0;
      step       <= '0;
      grp        <= GRP_FIRST;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      state      <= state_next;
      fill       <= fill_next;
      head_idx   <= head_idx_next;
      step       <= step_next;
      grp        <= grp_next;
      pend_valid <= pend_valid_next;
      strobe     <= emit;
    end
  end

  always_ff @(posedge clk) begin
    pend_data <= pend_data_next;
    pend_grp  <= pend_grp_next;
    if (emit) begin
      status <= emit_status;
      data   <= emit_data;
      group  <= emit_group;
      last   <= emit_last;
    end
  end

endmodule

[rtl/linear_queue_sort_bucket_top.sv]
// Top level of the linear queue with sort and categorize: a chain of DEPTH
// lqsb_cell entries, compacted at the head, driven by lqsb_ctrl.
// Depends on lqsb_pkg, lqsb_cell, lqsb_ctrl.
//
//   channel   handshake             word
//   command   start / busy          kind, value
//   result    strobe (no stall)     status, data, group, last
//
// Enqueue and dequeue results are registered and show in the cycle after the command.
// List makes one rotate of the cell chain per cycle over the N live entries, and sort
// one odd-even compare-exchange phase of the chain per cycle; categorize makes four
// rotations of the chain plus a closing word.
// Reset clears the counters and sequencer; entry cells are not cleared.
// The result side cannot stall: each word is flagged by strobe for a single cycle.
module linear_queue_sort_bucket_top #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [lqsb_pkg::KIND_W-1:0]   kind,
  input  logic [lqsb_pkg::VAL_W-1:0]    value,
  output logic                          strobe,
  output logic [lqsb_pkg::STAT_W-1:0]   status,
  output logic [lqsb_pkg::VAL_W-1:0]    data,
  output logic [lqsb_pkg::GRP_W-1:0]    group,
  output logic                          last
);
  import lqsb_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  cell_ctrl_t       cell_ctrl;
  logic [CW-1:0]    count;
  logic [VAL_W-1:0] q [DEPTH];

  lqsb_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .kind      (kind),
    .value     (value),
    .head_val  (q[0]),
    .busy      (busy),
    .cell_ctrl (cell_ctrl),
    .count     (count),
    .strobe    (strobe),
    .status    (status),
    .data      (data),
    .group     (group),
    .last      (last)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] left_q;
    logic [VAL_W-1:0] right_q;

    if (i == 0) begin : g_first
      assign left_q = q[i];
    end else begin : g_mid
      assign left_q = q[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign right_q = q[i];
    end else begin : g_inner
      assign right_q = q[i+1];
    end

    lqsb_cell #(.DEPTH(DEPTH), .IDX(i)) u_cell (
      .clk   (clk),
      .ctrl  (cell_ctrl),
      .count (count),
      .head  (q[0]),
      .left  (left_q),
      .right (right_q),
      .q     (q[i])
    );
  end

endmodule

[rtl/lqsb_checker.sv]
// Port-level checks for linear_queue_sort_bucket_top, bound to every instance.
// Depends on lqsb_pkg.
module lqsb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic [lqsb_pkg::KIND_W-1:0]   kind,
  input logic [lqsb_pkg::VAL_W-1:0]    value,
  input logic                          strobe,
  input logic [lqsb_pkg::STAT_W-1:0]   status,
  input logic [lqsb_pkg::VAL_W-1:0]    data,
  input logic [lqsb_pkg::GRP_W-1:0]    group,
  input logic                          last
);
  import lqsb_pkg::*;

  // enqueue and dequeue answer with a single word in the next cycle
  a_single_word: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (kind == KIND_ENQ || kind == KIND_DEQ)) |=> (strobe && last))
    else $error("enqueue or dequeue did not answer with one closing word");

  // leaving a walk always delivers the closing word
  a_walk_close: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (strobe && last))
    else $error("walk ended without a closing word");

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && status != STAT_OK) |-> (last && data == '0 && group == GRP_FIRST))
    else $error("error word not alone or carries data");

  a_value_value: assert property (@(posedge clk) disable iff (rst)
    (strobe && status == STAT_OK && group != GRP_FIRST) |-> (data >= LIM_G0 && data <= LIM_G3))
    else $error("grouped word outside group bounds");

endmodule

bind linear_queue_sort_bucket_top lqsb_checker u_lqsb_checker (.*);

[bench/linear_queue_sort_bucket_top_test.sv]
// Self-checking bench for linear_queue_sort_bucket_top: a directed table, then
// random commands; every result word is checked against the table's word or a queue shadow kept here.
// Depends on lqsb_pkg and the RTL of the block.
module linear_queue_sort_bucket_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lqsb_pkg::*;

  localparam int DEPTH = 16;
  localparam int RANDOM_CMDS = 300;
  localparam int DRAIN_CYCLES = 4 * DEPTH + 8;
  localparam int MAX_PRINTED = 40;

  // Kind codes the block must ignore.
  localparam logic [KIND_W-1:0] KIND_SPARE_5 = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

  localparam logic [VAL_W-1:0] BAND_EDGES [10] =
    '{7'd0, 7'd9, 7'd10, 7'd19, 7'd20, 7'd29, 7'd30, 7'd99, 7'd100, 7'd127};

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  data;
    logic [GRP_W-1:0]  group;
    logic              last;
  } word_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [VAL_W-1:0]  value;
    bit                typed;
    word_t             word;
  } table_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [KIND_W-1:0] kind = '0;
  logic [VAL_W-1:0]  value = '0;
  logic              busy;
  logic              strobe;
  logic [STAT_W-1:0] status;
  logic [VAL_W-1:0]  data;
  logic [GRP_W-1:0]  group;
  logic              last;

  // Shadow of the queue.
  logic [VAL_W-1:0] shadow_slot [DEPTH];
  int               head_at = 0;
  int               filled = 0;

  word_t fresh_words[$];
  word_t words_due[$];
  int    mismatches = 0;

  linear_queue_sort_bucket_top #(.DEPTH(DEPTH)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .value(value),
    .strobe(strobe), .status(status), .data(data), .group(group), .last(last)
  );

  always #6 clk = ~clk;

  function automatic word_t mk_word(input logic [STAT_W-1:0] st, input logic [VAL_W-1:0] d,
                                    input logic [GRP_W-1:0] g, input logic l);
    return '{st, d, g, l};
  endfunction

  // -1 for values that fall in no group.
  function automatic int band_of(input logic [VAL_W-1:0] v);
    if (v < 7'd10) return 0;
    if (v <= 7'd19) return 1;
    if (v <= 7'd29) return 2;
    if (v <= 7'd99) return 3;
    return -1;
  endfunction

  // Advance the shadow queue by one command and collect the words it causes.
  task automatic predict_command(input logic [KIND_W-1:0] k, input logic [VAL_W-1:0] v);
    int i;
    int j;
    int g;
    logic [VAL_W-1:0] t;
    fresh_words.delete();
    case (k)
      KIND_ENQ: begin
        if (filled >= DEPTH) begin
          fresh_words.push_back(mk_word(STAT_OVERFLOW, '0, '0, 1'b1));
        end else begin
          shadow_slot[filled] = v;
          filled++;
          fresh_words.push_back(mk_word(STAT_OK, '0, '0, 1'b1));
        end
      end
      KIND_DEQ: begin
        if (head_at >= filled) begin
          fresh_words.push_back(mk_word(STAT_EMPTY, '0, '0, 1'b1));
        end else begin
          fresh_words.push_back(mk_word(STAT_OK, shadow_slot[head_at], '0, 1'b1));
          head_at++;
        end
      end
      KIND_LIST: begin
        if (head_at >= filled) begin
          fresh_words.push_back(mk_word(STAT_EMPTY, '0, '0, 1'b1));
        end else begin
          for (i = head_at; i < filled; i++)
            fresh_words.push_back(mk_word(STAT_OK, shadow_slot[i], '0, i == filled - 1));
        end
      end
      KIND_SORT: begin
        // Only live slots take part.
        for (i = filled - 1; i > head_at; i--) begin
          for (j = head_at; j < i; j++) begin
            if (shadow_slot[j + 1] < shadow_slot[j]) begin
              t = shadow_slot[j];
              shadow_slot[j] = shadow_slot[j + 1];
              shadow_slot[j + 1] = t;
            end
          end
        end
        fresh_words.push_back(mk_word(STAT_OK, '0, '0, 1'b1));
      end
      KIND_CAT: begin
        if (head_at >= filled) begin
          fresh_words.push_back(mk_word(STAT_EMPTY, '0, '0, 1'b1));
        end else begin
          for (g = 0; g < 4; g++)
            for (i = head_at; i < filled; i++)
              if (band_of(shadow_slot[i]) == g)
                fresh_words.push_back(mk_word(STAT_OK, shadow_slot[i], g[GRP_W-1:0], 1'b0));
          if (fresh_words.size() == 0)
            fresh_words.push_back(mk_word(STAT_NO_GROUP, '0, '0, 1'b1));
          else
            fresh_words[fresh_words.size() - 1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  // Hold the command until accepted, then record the words it is due to cause.
  task automatic send_command(input logic [KIND_W-1:0] k, input logic [VAL_W-1:0] v,
                              input bit typed, input word_t typed_word, input bit may_idle);
    start <= 1'b1;
    kind <= k;
    value <= v;
    do @(posedge clk); while (busy);
    predict_command(k, v);
    if (typed) begin
      words_due.push_back(typed_word);
    end else begin
      foreach (fresh_words[i]) words_due.push_back(fresh_words[i]);
    end
    // keep start low while a random draw falls below 16 out of 100
    if (may_idle) begin
      while ($urandom_range(0, 99) < 16) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  always @(posedge clk) begin : check_words
    word_t seen;
    word_t want;
    if (!rst && strobe) begin
      seen = {status, data, group, last};
      if (words_due.size() == 0) begin
        report_mismatch($sformatf("word %h with nothing due", seen));
      end else begin
        want = words_due.pop_front();
        if (seen.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", seen.status, want.status));
        if (seen.data !== want.data)
          report_mismatch($sformatf("data %0d, want %0d", seen.data, want.data));
        if (seen.group !== want.group)
          report_mismatch($sformatf("group %0d, want %0d", seen.group, want.group));
        if (seen.last !== want.last)
          report_mismatch($sformatf("last %0d, want %0d", seen.last, want.last));
      end
    end
  end

  initial begin
    table_row_t rows[$];
    int counted;
    int r;
    logic [KIND_W-1:0] k;
    logic [VAL_W-1:0] v;

    rows.push_back('{KIND_DEQ,  7'd0,   1'b1, mk_word(STAT_EMPTY, '0, '0, 1'b1)});
    rows.push_back('{KIND_LIST, 7'd127, 1'b1, mk_word(STAT_EMPTY, '0, '0, 1'b1)});
    rows.push_back('{KIND_SORT, 7'd85,  1'b1, mk_word(STAT_OK, '0, '0, 1'b1)});
    rows.push_back('{KIND_CAT,  7'd42,  1'b1, mk_word(STAT_EMPTY, '0, '0, 1'b1)});
    rows.push_back('{KIND_SPARE_5, 7'd127, 1'b0, '0});
    rows.push_back('{KIND_SPARE_6, 7'd0,   1'b0, '0});
    rows.push_back('{KIND_SPARE_7, 7'd85,  1'b0, '0});
    rows.push_back('{KIND_ENQ,  7'd127, 1'b1, mk_word(STAT_OK, '0, '0, 1'b1)});
    // A lone value above the top group leaves categorize with nothing to emit.
    rows.push_back('{KIND_CAT,  7'd0,   1'b1, mk_word(STAT_NO_GROUP, '0, '0, 1'b1)});
    rows.push_back('{KIND_LIST, 7'd0,   1'b1, mk_word(STAT_OK, 7'd127, '0, 1'b1)});
    rows.push_back('{KIND_ENQ,  7'd0,   1'b1, mk_word(STAT_OK, '0, '0, 1'b1)});
    rows.push_back('{KIND_ENQ,  7'd99,  1'b1, mk_word(STAT_OK, '0, '0, 1'b1)});
    rows.push_back('{KIND_ENQ,  7'd100, 1'b1, mk_word(STAT_OK, '0, '0, 1'b1)});
    rows.push_back('{KIND_ENQ,  7'd9,   1'b1, mk_word(STAT_OK, '0, '0, 1'b1)});
    rows.push_back('{KIND_SORT, 7'd127, 1'b1, mk_word(STAT_OK, '0, '0, 1'b1)});
    rows.push_back('{KIND_LIST, 7'd42,  1'b0, '0});
    rows.push_back('{KIND_CAT,  7'd127, 1'b0, '0});
    repeat (5) rows.push_back('{KIND_DEQ, 7'd85, 1'b0, '0});
    rows.push_back('{KIND_DEQ,  7'd127, 1'b1, mk_word(STAT_EMPTY, '0, '0, 1'b1)});
    rows.push_back('{KIND_LIST, 7'd0,   1'b1, mk_word(STAT_EMPTY, '0, '0, 1'b1)});
    rows.push_back('{KIND_CAT,  7'd127, 1'b1, mk_word(STAT_EMPTY, '0, '0, 1'b1)});

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_command(rows[i].kind, rows[i].value, rows[i].typed, rows[i].word, 1'b1);

    // Fill the queue early, then mostly inspect it while it drains slowly.
    counted = 0;
    while (counted < RANDOM_CMDS) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 1) == 1) v = BAND_EDGES[$urandom_range(0, 9)];
      else v = VAL_W'($urandom_range(0, 127));
      if (r < 4) k = KIND_W'($urandom_range(KIND_SPARE_5, KIND_SPARE_7));
      else if (filled < DEPTH) begin
        if (r < 59) k = KIND_ENQ;
        else if (r < 63) k = KIND_DEQ;
        else if (r < 75) k = KIND_LIST;
        else if (r < 87) k = KIND_SORT;
        else k = KIND_CAT;
      end else begin
        if (r < 16) k = KIND_ENQ;
        else if (r < 22) k = KIND_DEQ;
        else if (r < 50) k = KIND_LIST;
        else if (r < 70) k = KIND_SORT;
        else k = KIND_CAT;
      end
      send_command(k, v, 1'b0, '0, !(counted >= 100 && counted < 180));
      if (k <= KIND_CAT) counted++;
    end

    start <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
